// ===== hw/rtl/mis_pkg.sv =====
`default_nettype none

package mis_pkg;

   localparam int PIXEL_W = 32;
   localparam int POS_W   = 12;
   localparam int DIM_W   = 13;
   localparam int PAD_W   = 8;
   localparam int COUNT_W = 25;
   localparam int SIDE_W  = 2;
   localparam int NUM_SIDES = 4;
   // Wide enough for grid_left + grid_width + pad and for any image size clamp
   localparam int GEOM_W  = 15;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_LEFT    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_TOP     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_WIDTH   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_HEIGHT  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_MARGIN_PAD   = 3'd6;

   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;
   localparam logic [PAD_W-1:0] MARGIN_PAD_RESET   = 8'd10;

   localparam logic [23:0] BLACK_MASK = 24'hFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd3;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_word;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [SIDE_W-1:0]  side;
      logic [POS_W-1:0]   region_x;
      logic [POS_W-1:0]   region_y;
      logic [DIM_W-1:0]   region_w;
      logic [DIM_W-1:0]   region_h;
      logic [COUNT_W-1:0] ink_count;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [POS_W-1:0] grid_left;
      logic [POS_W-1:0] grid_top;
      logic [DIM_W-1:0] grid_width;
      logic [DIM_W-1:0] grid_height;
      logic [PAD_W-1:0] margin_pad;
   } cfg_type;

   typedef struct packed {
      logic [GEOM_W-1:0]    img_w;
      logic [GEOM_W-1:0]    img_h;
      logic [POS_W-1:0]     left_w;
      logic [GEOM_W-1:0]    right_x;
      logic [POS_W-1:0]     top_h;
      logic [GEOM_W-1:0]    lower_y;
      logic [NUM_SIDES-1:0] ok;
   } band_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mis_bands.sv =====
`default_nettype none

module mis_bands
   import mis_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  wire logic     clock,
   input  wire cfg_type  cfg,
   output band_type      band
);

   localparam logic [GEOM_W-1:0] DIM_LIMIT = GEOM_W'(MAX_DIM);

   band_type          band_ff;
   band_type          band_in;
   logic [GEOM_W-1:0] w_raw;
   logic [GEOM_W-1:0] h_raw;
   logic [GEOM_W-1:0] pad_ext;

   always_comb begin
      w_raw   = GEOM_W'(cfg.image_width);
      h_raw   = GEOM_W'(cfg.image_height);
      pad_ext = GEOM_W'(cfg.margin_pad);

      band_in.img_w = (w_raw > DIM_LIMIT) ? DIM_LIMIT : w_raw;
      band_in.img_h = (h_raw > DIM_LIMIT) ? DIM_LIMIT : h_raw;

      band_in.left_w = (GEOM_W'(cfg.grid_left) > pad_ext) ?
                       (cfg.grid_left - POS_W'(cfg.margin_pad)) : '0;
      band_in.top_h  = (GEOM_W'(cfg.grid_top) > pad_ext) ?
                       (cfg.grid_top - POS_W'(cfg.margin_pad)) : '0;

      band_in.right_x = GEOM_W'(cfg.grid_left) + GEOM_W'(cfg.grid_width) + pad_ext;
      band_in.lower_y = GEOM_W'(cfg.grid_top) + GEOM_W'(cfg.grid_height) + pad_ext;

      band_in.ok[SIDE_LEFT]   = (band_in.left_w != '0) &&
                                (GEOM_W'(band_in.left_w) <= band_in.img_w) &&
                                (band_in.img_h != '0);
      band_in.ok[SIDE_RIGHT]  = (band_in.right_x < band_in.img_w) &&
                                (band_in.img_h != '0);
      band_in.ok[SIDE_TOP]    = (band_in.top_h != '0) &&
                                (GEOM_W'(band_in.top_h) <= band_in.img_h) &&
                                (band_in.img_w != '0);
      band_in.ok[SIDE_BOTTOM] = (band_in.lower_y < band_in.img_h) &&
                                (band_in.img_w != '0);
   end

   // Tracks the registers; user must change them only while idle, unchecked
   always_ff @(posedge clock) begin
      band_ff <= band_in;
   end

   assign band = band_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/margin_ink_selector.sv =====
// Result path: a pixel marked frame_end passes the input register, the count snapshot and the
//   output register before its result shows on rsp_valid, and transfers on the next edge with rsp_ready.
// Throughput: one pixel per cycle except for the stall below; counting runs in a single counter stage.
// A waiting result stalls input only when a frame end meets a held snapshot.
// Reset (synchronous, active high) loads register defaults and clears all counters.
`default_nettype none

module margin_ink_selector
   import mis_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff;
   band_type band;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    in_go;

   logic [NUM_SIDES-1:0][COUNT_W-1:0] cnt_ff;
   logic [NUM_SIDES-1:0][COUNT_W-1:0] cnt_in;
   logic [NUM_SIDES-1:0]              hit;

   logic                              snap_valid_ff;
   logic [NUM_SIDES-1:0][COUNT_W-1:0] snap_ff;
   logic                              snap_go;
   logic                              snap_free;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    out_free;

   logic               pix_black;
   logic               pix_in_image;
   logic [GEOM_W-1:0]  px;
   logic [GEOM_W-1:0]  py;
   logic [COUNT_W-1:0] best;
   logic [SIDE_W-1:0]  sel;

   mis_bands #(
      .MAX_DIM (MAX_DIM)
   ) u_bands (
      .clock (clock),
      .cfg   (cfg_ff),
      .band  (band)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= IMAGE_WIDTH_RESET;
         cfg_ff.image_height <= IMAGE_HEIGHT_RESET;
         cfg_ff.grid_left    <= '0;
         cfg_ff.grid_top     <= '0;
         cfg_ff.grid_width   <= '0;
         cfg_ff.grid_height  <= '0;
         cfg_ff.margin_pad   <= MARGIN_PAD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_data;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_data;
            CSR_GRID_LEFT:    cfg_ff.grid_left    <= csr_data[POS_W-1:0];
            CSR_GRID_TOP:     cfg_ff.grid_top     <= csr_data[POS_W-1:0];
            CSR_GRID_WIDTH:   cfg_ff.grid_width   <= csr_data;
            CSR_GRID_HEIGHT:  cfg_ff.grid_height  <= csr_data;
            CSR_MARGIN_PAD:   cfg_ff.margin_pad   <= csr_data[PAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake chain: output register <- snapshot <- input register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign snap_go   = snap_valid_ff && out_free;
   assign snap_free = !snap_valid_ff || snap_go;
   assign in_go     = in_valid_ff && (!in_data_ff.frame_end || snap_free);
   assign req_ready = !in_valid_ff || in_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_comb begin
      px           = GEOM_W'(in_data_ff.pos_x);
      py           = GEOM_W'(in_data_ff.pos_y);
      pix_black    = (in_data_ff.pixel_word[23:0] & BLACK_MASK) == '0;
      pix_in_image = (px < band.img_w) && (py < band.img_h);

      hit[SIDE_LEFT]   = band.ok[SIDE_LEFT]   && (in_data_ff.pos_x < band.left_w);
      hit[SIDE_RIGHT]  = band.ok[SIDE_RIGHT]  && (px >= band.right_x);
      hit[SIDE_TOP]    = band.ok[SIDE_TOP]    && (in_data_ff.pos_y < band.top_h);
      hit[SIDE_BOTTOM] = band.ok[SIDE_BOTTOM] && (py >= band.lower_y);

      for (int k = 0; k < NUM_SIDES; k++) begin
         cnt_in[k] = (pix_black && pix_in_image && hit[k] && (cnt_ff[k] != COUNT_MAX)) ?
                     (cnt_ff[k] + COUNT_W'(1)) : cnt_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (in_go) begin
         // Frame end: hand the final counts to the snapshot and start over
         cnt_ff <= in_data_ff.frame_end ? '0 : cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (snap_free) begin
         snap_valid_ff <= in_go && in_data_ff.frame_end;
      end
      if (in_go && in_data_ff.frame_end) begin
         snap_ff <= cnt_in;
      end
   end

   // Later bands win only on a strictly greater count
   always_comb begin
      best = snap_ff[SIDE_LEFT];
      sel  = SIDE_LEFT;
      if (snap_ff[SIDE_RIGHT] > best && band.ok[SIDE_RIGHT]) begin
         best = snap_ff[SIDE_RIGHT];
         sel  = SIDE_RIGHT;
      end
      if (snap_ff[SIDE_TOP] > best && band.ok[SIDE_TOP]) begin
         best = snap_ff[SIDE_TOP];
         sel  = SIDE_TOP;
      end
      if (snap_ff[SIDE_BOTTOM] > best && band.ok[SIDE_BOTTOM]) begin
         best = snap_ff[SIDE_BOTTOM];
         sel  = SIDE_BOTTOM;
      end

      rsp_data_in           = '0;
      rsp_data_in.side      = sel;
      rsp_data_in.ink_count = best;
      unique case (sel)
         SIDE_LEFT: begin
            rsp_data_in.region_w = DIM_W'(band.left_w);
            rsp_data_in.region_h = band.img_h[DIM_W-1:0];
         end
         SIDE_RIGHT: begin
            rsp_data_in.region_x = band.right_x[POS_W-1:0];
            rsp_data_in.region_w = DIM_W'(band.img_w - band.right_x);
            rsp_data_in.region_h = band.img_h[DIM_W-1:0];
         end
         SIDE_TOP: begin
            rsp_data_in.region_w = band.img_w[DIM_W-1:0];
            rsp_data_in.region_h = DIM_W'(band.top_h);
         end
         SIDE_BOTTOM: begin
            rsp_data_in.region_y = band.lower_y[POS_W-1:0];
            rsp_data_in.region_w = band.img_w[DIM_W-1:0];
            rsp_data_in.region_h = DIM_W'(band.img_h - band.lower_y);
         end
      endcase

      if (best == '0) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in.found = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= snap_valid_ff;
      end
      if (snap_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_found_has_ink: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.found == (rsp_data_ff.ink_count != '0)))
      else $error("found flag disagrees with ink count");

   a_counters_cleared: assert property (@(posedge clock) disable iff (reset)
      (in_go && in_data_ff.frame_end) |=>
         (cnt_ff[SIDE_LEFT] == '0) && (cnt_ff[SIDE_RIGHT] == '0) &&
         (cnt_ff[SIDE_TOP] == '0) && (cnt_ff[SIDE_BOTTOM] == '0))
      else $error("counters not cleared after frame end");

   a_snap_held: assert property (@(posedge clock) disable iff (reset)
      (snap_valid_ff && !out_free) |=> (snap_valid_ff && $stable(snap_ff)))
      else $error("pending snapshot lost while output stalled");

   a_frame_end_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_data_ff.frame_end && !snap_free) |-> !req_ready)
      else $error("input accepted while frame end is stalled");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mis_pkg::*;

   localparam int unsigned DIM_LIMIT       = 4096;
   localparam int unsigned SETTLE_CYCLES   = 10;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned REPORT_LIMIT    = 10;

   typedef struct {
      int unsigned x;
      int unsigned y;
      int unsigned w;
      int unsigned h;
      bit          ok;
   } band_geom_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cfg_type     margin_cfg;
   int unsigned band_ink [NUM_SIDES];
   rsp_type     expected_picks [$];
   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   bit          rsp_hold;
   event        hold_rsp_start;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   margin_ink_selector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input int unsigned v);
      return (v > DIM_LIMIT) ? DIM_LIMIT : v;
   endfunction

   function automatic band_geom_type band_of(input logic [SIDE_W-1:0] s);
      int unsigned   img_w;
      int unsigned   img_h;
      int unsigned   pad;
      int unsigned   span;
      int unsigned   start;
      band_geom_type b;
      img_w = clamp_dim(margin_cfg.image_width);
      img_h = clamp_dim(margin_cfg.image_height);
      pad   = margin_cfg.margin_pad;
      case (s)
         SIDE_LEFT: begin
            span = (margin_cfg.grid_left > pad) ? margin_cfg.grid_left - pad : 0;
            b = '{x: 0, y: 0, w: span, h: img_h,
                  ok: span > 0 && span <= img_w && img_h > 0};
         end
         SIDE_RIGHT: begin
            start = margin_cfg.grid_left + margin_cfg.grid_width + pad;
            span  = (start < img_w) ? img_w - start : 0;
            b = '{x: start, y: 0, w: span, h: img_h, ok: span > 0 && img_h > 0};
         end
         SIDE_TOP: begin
            span = (margin_cfg.grid_top > pad) ? margin_cfg.grid_top - pad : 0;
            b = '{x: 0, y: 0, w: img_w, h: span,
                  ok: span > 0 && span <= img_h && img_w > 0};
         end
         default: begin
            start = margin_cfg.grid_top + margin_cfg.grid_height + pad;
            span  = (start < img_h) ? img_h - start : 0;
            b = '{x: 0, y: start, w: img_w, h: span, ok: span > 0 && img_w > 0};
         end
      endcase
      return b;
   endfunction

   // Count one pixel into the bands; on a frame end, pick the band with most ink.
   task automatic tally_pixel(input req_type p);
      band_geom_type     geom [NUM_SIDES];
      int unsigned       best;
      logic [SIDE_W-1:0] pick;
      rsp_type           pick_rsp;
      for (int k = 0; k < NUM_SIDES; k++)
         geom[k] = band_of(SIDE_W'(k));
      if ((p.pixel_word[23:0] & BLACK_MASK) == '0
          && p.pos_x < clamp_dim(margin_cfg.image_width)
          && p.pos_y < clamp_dim(margin_cfg.image_height)) begin
         for (int k = 0; k < NUM_SIDES; k++) begin
            if (geom[k].ok && p.pos_x >= geom[k].x && p.pos_x - geom[k].x < geom[k].w
                && p.pos_y >= geom[k].y && p.pos_y - geom[k].y < geom[k].h
                && band_ink[k] < COUNT_MAX)
               band_ink[k]++;
         end
      end
      if (p.frame_end) begin
         best = band_ink[0];
         pick = SIDE_LEFT;
         // a later band wins only with a strictly larger count
         for (int k = 1; k < NUM_SIDES; k++) begin
            if (band_ink[k] > best && geom[k].ok) begin
               best = band_ink[k];
               pick = SIDE_W'(k);
            end
         end
         pick_rsp = '0;
         if (best != 0) begin
            pick_rsp.found     = 1'b1;
            pick_rsp.side      = pick;
            pick_rsp.region_x  = POS_W'(geom[pick].x);
            pick_rsp.region_y  = POS_W'(geom[pick].y);
            pick_rsp.region_w  = DIM_W'(geom[pick].w);
            pick_rsp.region_h  = DIM_W'(geom[pick].h);
            pick_rsp.ink_count = COUNT_W'(best);
         end
         expected_picks.push_back(pick_rsp);
         for (int k = 0; k < NUM_SIDES; k++)
            band_ink[k] = 0;
      end
   endtask

   task automatic send_pixel(input req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tally_pixel(p);
   endtask

   // Drop the input, wait for every pending result, then let the pipeline empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_IMAGE_WIDTH:  margin_cfg.image_width  = value;
         CSR_IMAGE_HEIGHT: margin_cfg.image_height = value;
         CSR_GRID_LEFT:    margin_cfg.grid_left    = value[POS_W-1:0];
         CSR_GRID_TOP:     margin_cfg.grid_top     = value[POS_W-1:0];
         CSR_GRID_WIDTH:   margin_cfg.grid_width   = value;
         CSR_GRID_HEIGHT:  margin_cfg.grid_height  = value;
         CSR_MARGIN_PAD:   margin_cfg.margin_pad   = value[PAD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_config(input cfg_type c);
      drain_results();
      write_register(CSR_IMAGE_WIDTH,  c.image_width);
      write_register(CSR_IMAGE_HEIGHT, c.image_height);
      write_register(CSR_GRID_LEFT,    CSR_DATA_W'(c.grid_left));
      write_register(CSR_GRID_TOP,     CSR_DATA_W'(c.grid_top));
      write_register(CSR_GRID_WIDTH,   c.grid_width);
      write_register(CSR_GRID_HEIGHT,  c.grid_height);
      write_register(CSR_MARGIN_PAD,   CSR_DATA_W'(c.margin_pad));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_pixel(input logic [PIXEL_W-1:0] word,
                                          input int unsigned x, input int unsigned y,
                                          input bit last);
      req_type p;
      p.pixel_word = word;
      p.pos_x      = POS_W'(x);
      p.pos_y      = POS_W'(y);
      p.frame_end  = last;
      return p;
   endfunction

   function automatic req_type random_pixel(input bit last);
      req_type     p;
      int unsigned img_w;
      int unsigned img_h;
      img_w = clamp_dim(margin_cfg.image_width);
      img_h = clamp_dim(margin_cfg.image_height);
      p.pixel_word = $urandom;
      if ($urandom_range(99) < 55)
         p.pixel_word[23:0] = '0;
      // mostly inside the frame; now and then anywhere, often off the image
      if ($urandom_range(99) < 8 || img_w == 0 || img_h == 0) begin
         p.pos_x = POS_W'($urandom);
         p.pos_y = POS_W'($urandom);
      end else begin
         p.pos_x = POS_W'($urandom_range(img_w - 1));
         p.pos_y = POS_W'($urandom_range(img_h - 1));
      end
      p.frame_end = last;
      return p;
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.image_width  = DIM_W'($urandom_range(64, 6));
      c.image_height = DIM_W'($urandom_range(64, 6));
      c.margin_pad   = PAD_W'($urandom_range(6));
      c.grid_left    = POS_W'($urandom_range(c.image_width));
      c.grid_top     = POS_W'($urandom_range(c.image_height));
      c.grid_width   = DIM_W'($urandom_range(c.image_width / 2));
      c.grid_height  = DIM_W'($urandom_range(c.image_height / 2));
      case ($urandom_range(9))
         0: c.margin_pad = PAD_W'($urandom);
         1: begin
            c.image_width  = DIM_W'($urandom);
            c.image_height = DIM_W'($urandom);
         end
         2: begin
            c.grid_left  = POS_W'($urandom);
            c.grid_width = DIM_W'($urandom);
         end
         3: begin
            c.grid_top    = POS_W'($urandom);
            c.grid_height = DIM_W'($urandom);
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic test_reset_defaults();
      send_idle_pct = 23;
      rsp_idle_pct  = 48;
      send_pixel(make_pixel(32'h0000_0000, 5, 5, 1'b0));
      send_pixel(make_pixel(32'h8000_0000, 20, 20, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 700, 20, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 639, 479, 1'b0));
      send_pixel(make_pixel(32'h0012_3456, 0, 479, 1'b1));
   endtask

   task automatic test_directed_corners();
      write_config('{image_width: 13'd4096, image_height: 13'd4096, grid_left: 12'd100,
                     grid_top: 12'd200, grid_width: 13'd50, grid_height: 13'd60,
                     margin_pad: 8'd0});
      // left and bottom tie, left must win
      send_pixel(make_pixel(32'hFF00_0000, 0, 0, 1'b0));
      send_pixel(make_pixel(32'h0000_0001, 4095, 4095, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 4095, 4095, 1'b0));
      send_pixel(make_pixel(32'hFFFF_FFFF, 0, 4095, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 5, 300, 1'b0));
      send_pixel(make_pixel(32'h0080_0000, 120, 220, 1'b1));
      // bottom strictly ahead, frame end pixel counted too
      send_pixel(make_pixel(32'h7F00_0000, 120, 4000, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 121, 4001, 1'b0));
      send_pixel(make_pixel(32'h0100_0000, 122, 4002, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 120, 4095, 1'b1));
      // no ink at all
      send_pixel(make_pixel(32'h00FF_FFFF, 0, 0, 1'b1));

      // oversize image, widest grid and pad; right and top bands empty
      write_config('{image_width: 13'd8191, image_height: 13'd5000, grid_left: 12'd4095,
                     grid_top: 12'd0, grid_width: 13'd8191, grid_height: 13'd0,
                     margin_pad: 8'd255});
      send_pixel(make_pixel(32'h0000_0000, 4095, 100, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 3839, 4095, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 3840, 0, 1'b1));

      // left and top bands reach past the image, right and bottom empty
      write_config('{image_width: 13'd100, image_height: 13'd100, grid_left: 12'd300,
                     grid_top: 12'd150, grid_width: 13'd0, grid_height: 13'd0,
                     margin_pad: 8'd0});
      send_pixel(make_pixel(32'h0000_0000, 50, 50, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 200, 50, 1'b0));
      send_pixel(make_pixel(32'h0000_0000, 10, 99, 1'b1));

      // zero-sized image holds no pixel
      write_config('{image_width: 13'd0, image_height: 13'd0, grid_left: 12'd300,
                     grid_top: 12'd150, grid_width: 13'd4096, grid_height: 13'd4096,
                     margin_pad: 8'd10});
      send_pixel(make_pixel(32'h0000_0000, 0, 0, 1'b1));
   endtask

   task automatic test_random_frames(input int unsigned send_pct, input int unsigned stall_pct,
                                     input int unsigned n_pixels);
      int unsigned sent;
      int unsigned frame_len;
      send_idle_pct = send_pct;
      rsp_idle_pct  = stall_pct;
      sent = 0;
      while (sent < n_pixels) begin
         write_config(random_config());
         repeat ($urandom_range(6, 2)) begin
            frame_len = $urandom_range(24, 1);
            for (int i = 1; i <= frame_len; i++)
               send_pixel(random_pixel(i == frame_len));
            sent += frame_len;
         end
      end
   endtask

   // Hold the receiver off while short frames pile up results inside the block.
   task automatic test_full_pipeline_stall();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      write_config(random_config());
      -> hold_rsp_start;
      for (int i = 0; i < 60; i++)
         send_pixel(random_pixel(i == 59 || $urandom_range(2) == 0));
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      margin_cfg = '{image_width: IMAGE_WIDTH_RESET, image_height: IMAGE_HEIGHT_RESET,
                     grid_left: '0, grid_top: '0, grid_width: '0, grid_height: '0,
                     margin_pad: MARGIN_PAD_RESET};
      for (int k = 0; k < NUM_SIDES; k++)
         band_ink[k] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_corners();
      test_random_frames(23, 48, 130);
      test_random_frames(48, 23, 130);
      test_random_frames(0, 0, 130);
      test_full_pipeline_stall();

      drain_results();
      if (mismatches == 0 && expected_picks.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(hold_rsp_start);
         rsp_hold <= 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result transfer with none expected: %p", $realtime, rsp_data);
         end else begin
            want = expected_picks.pop_front();
            check_field("found", want.found, rsp_data.found);
            check_field("side", want.side, rsp_data.side);
            check_field("region_x", want.region_x, rsp_data.region_x);
            check_field("region_y", want.region_y, rsp_data.region_y);
            check_field("region_w", want.region_w, rsp_data.region_w);
            check_field("region_h", want.region_h, rsp_data.region_h);
            check_field("ink_count", want.ink_count, rsp_data.ink_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_picks.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
